// ===== sv/dhcprp_pkg.sv =====
// Shared constants, register indexes and result type of the DHCP reply parser.
package dhcprp_pkg;

	localparam int DEFAULT_MAX_DNS = 3;

	localparam int POS_W = 17;
	localparam logic [POS_W-1:0] POS_MAX = 17'h1FFFF;

	localparam logic [7:0] ETYPE_HI = 8'h08;
	localparam logic [7:0] ETYPE_LO = 8'h00;
	localparam logic [7:0] IP_PROTO_UDP = 8'd17;
	localparam logic [7:0] CLIENT_PORT = 8'd68;
	localparam logic [7:0] BOOTREPLY = 8'd2;
	localparam logic [31:0] MAGIC_COOKIE = 32'h63825363;
	localparam logic [15:0] MIN_UDP_LEN = 16'd248;
	localparam logic [7:0] MSG_OFFER = 8'd2;

	localparam logic [7:0] OPT_PAD = 8'd0;
	localparam logic [7:0] OPT_MASK = 8'd1;
	localparam logic [7:0] OPT_ROUTER = 8'd3;
	localparam logic [7:0] OPT_DNS = 8'd6;
	localparam logic [7:0] OPT_LEASE = 8'd51;
	localparam logic [7:0] OPT_TYPE = 8'd53;
	localparam logic [7:0] OPT_SERVER = 8'd54;
	localparam logic [7:0] OPT_T1 = 8'd58;
	localparam logic [7:0] OPT_T2 = 8'd59;
	localparam logic [7:0] OPT_END = 8'd255;

	localparam int ADDR_W = 5;
	localparam logic [1:0] REG_XID = 2'd0;
	localparam logic [1:0] REG_CHADDR = 2'd1;
	localparam logic [1:0] REG_TYPES = 2'd2;

	typedef struct packed {
		logic [7:0]  message_type;
		logic [31:0] offered_ip;
		logic [31:0] subnet_mask;
		logic [31:0] router_addr;
		logic [31:0] server_id;
		logic [31:0] lease_secs;
		logic [31:0] renew_secs;
		logic [31:0] rebind_secs;
		logic [47:0] server_hw_addr;
	} lease_t;

endpackage

// ===== sv/dhcprp_run_buf.sv =====
// Result register that plays out one accepted frame as a run of results.
module dhcprp_run_buf #(
	parameter int MAX_DNS = dhcprp_pkg::DEFAULT_MAX_DNS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  dhcprp_pkg::lease_t lease_in,
	input  logic [31:0] dns_in [MAX_DNS],
	input  logic [$clog2(MAX_DNS+1)-1:0] dns_cnt_in,
	output logic busy,
	output logic out_valid,
	input  logic out_ready,
	output dhcprp_pkg::lease_t lease_out,
	output logic dns_valid,
	output logic [31:0] dns_addr,
	output logic last_of_run
);
	localparam int CW = $clog2(MAX_DNS + 1);
	localparam int IW = (MAX_DNS > 1) ? $clog2(MAX_DNS) : 1;

	logic busy_q;
	logic has_dns_q;
	logic [CW-1:0] cnt_q;
	logic [IW-1:0] idx_q;
	dhcprp_pkg::lease_t lease_q;
	logic [31:0] dns_q [MAX_DNS];
	logic at_last;

	assign at_last = (CW'(idx_q) + CW'(1)) == cnt_q;
	assign busy = busy_q;
	assign out_valid = busy_q;
	assign lease_out = lease_q;
	assign dns_valid = has_dns_q;
	assign dns_addr = has_dns_q ? dns_q[idx_q] : 32'd0;
	assign last_of_run = at_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			has_dns_q <= 1'b0;
			cnt_q <= '0;
			idx_q <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			has_dns_q <= dns_cnt_in != '0;
			cnt_q <= (dns_cnt_in == '0) ? CW'(1) : dns_cnt_in;
			idx_q <= '0;
		end else if (busy_q && out_ready) begin
			if (at_last) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + IW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			lease_q <= lease_in;
			for (int i = 0; i < MAX_DNS; i++) begin
				dns_q[i] <= dns_in[i];
			end
		end
	end

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> !busy_q) else $error("run loaded while previous run pending");
	a_cnt_nz: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (cnt_q != '0 && CW'(idx_q) < cnt_q)) else $error("bad run index");
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !has_dns_q) |-> cnt_q == CW'(1)) else $error("run without servers too long");
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && out_ready && at_last && !load) |=> !busy_q) else $error("run did not end");

endmodule

// ===== sv/dhcp_reply_parser.sv =====
// Top level: frame byte walker, header checks, option extraction and APB registers.
//   channel | signals                                 | direction
//   in      | in_valid, in_ready, frame_byte, end_of_frame | into block
//   out     | out_valid, out_ready, result fields     | out of block
//   cfg     | psel, penable, pwrite, paddr, pwdata, prdata, pready | APB
// One frame byte is taken per cycle unless a final byte is held; each byte passes an
// input register and the compare and capture logic. A final byte of an accepted frame loads the
// result register, which gives one result per cycle while out_ready is high, up to MAX_DNS of them.
// A final byte waits in the input register while an earlier run is still pending.
// Reset clears all frame state; the registers reset to zero.
module dhcp_reply_parser #(
	parameter int MAX_DNS = dhcprp_pkg::DEFAULT_MAX_DNS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [7:0] frame_byte,
	input  logic end_of_frame,
	output logic out_valid,
	input  logic out_ready,
	output logic [7:0] message_type,
	output logic [31:0] offered_ip,
	output logic [31:0] subnet_mask,
	output logic [31:0] router_addr,
	output logic [31:0] server_id,
	output logic [31:0] lease_secs,
	output logic [31:0] renew_secs,
	output logic [31:0] rebind_secs,
	output logic [47:0] server_hw_addr,
	output logic dns_valid,
	output logic [31:0] dns_addr,
	output logic last_of_run,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [dhcprp_pkg::ADDR_W-1:0] paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic pready
);
	localparam int CW = $clog2(MAX_DNS + 1);
	localparam int PW = dhcprp_pkg::POS_W;

	typedef enum logic [1:0] {PH_CODE, PH_LEN, PH_VALUE, PH_DONE} phase_t;

	logic [31:0] xid_q;
	logic [47:0] chaddr_q;
	logic [7:0] types_q;

	logic valid_s1, last_s1;
	logic [7:0] byte_s1;
	logic go, busy, load, accept_frame;

	logic [PW-1:0] pos_q;
	logic [5:0] ihl_q, ihl_d;
	logic [15:0] udp_len_q, udp_len_d;
	logic ok_q, ok_d;
	phase_t phase_q, phase_d;
	logic [7:0] code_q, code_d, remain_q, remain_d, taken_q, taken_d;
	logic [31:0] shift_q, shift_d;
	logic [7:0] type_q, type_d;
	logic [31:0] yiaddr_q, yiaddr_d, mask_q, mask_d, router_q, router_d;
	logic [31:0] server_q, server_d, lease_q, lease_d, t1_q, t1_d, t2_q, t2_d;
	logic [47:0] smac_q, smac_d;
	logic [31:0] store_q [MAX_DNS];
	logic [31:0] store_d [MAX_DNS];
	logic [31:0] pend_q [MAX_DNS];
	logic [31:0] pend_d [MAX_DNS];
	logic [CW-1:0] cnt_q, cnt_d, pcnt_q, pcnt_d;

	dhcprp_pkg::lease_t lease_res, lease_out;

	// Configuration registers.
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xid_q <= '0;
			chaddr_q <= '0;
			types_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (paddr[4:3])
				dhcprp_pkg::REG_XID: xid_q <= pwdata[31:0];
				dhcprp_pkg::REG_CHADDR: chaddr_q <= pwdata[47:0];
				dhcprp_pkg::REG_TYPES: types_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:3])
			dhcprp_pkg::REG_XID: prdata = {32'd0, xid_q};
			dhcprp_pkg::REG_CHADDR: prdata = {16'd0, chaddr_q};
			dhcprp_pkg::REG_TYPES: prdata = {56'd0, types_q};
			default: prdata = '0;
		endcase
	end

	// Input register; a final byte holds here until the result register is free.
	assign go = valid_s1 && !(last_s1 && busy);
	assign in_ready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= frame_byte;
			last_s1 <= end_of_frame;
		end
	end

	// Per-byte checks and captures.
	always_comb begin
		logic [7:0] v;
		logic [PW-1:0] p, udp_base, r, q;
		logic [5:0] slot;
		logic [7:0] want;
		logic commit;
		logic [PW:0] frame_len, opt0;
		logic [2:0] mac_idx;
		logic [47:0] mac_sh;
		v = byte_s1;
		p = pos_q;
		ihl_d = ihl_q;
		udp_len_d = udp_len_q;
		ok_d = ok_q;
		phase_d = phase_q;
		code_d = code_q;
		remain_d = remain_q;
		taken_d = taken_q;
		shift_d = shift_q;
		type_d = type_q;
		yiaddr_d = yiaddr_q;
		mask_d = mask_q;
		router_d = router_q;
		server_d = server_q;
		lease_d = lease_q;
		t1_d = t1_q;
		t2_d = t2_q;
		smac_d = smac_q;
		cnt_d = cnt_q;
		pcnt_d = pcnt_q;
		for (int i = 0; i < MAX_DNS; i++) begin
			store_d[i] = store_q[i];
			pend_d[i] = pend_q[i];
		end
		commit = 1'b0;
		slot = taken_q[7:2];
		want = '0;

		if (p >= PW'(6) && p <= PW'(11)) smac_d = {smac_q[39:0], v};
		if (p == PW'(12) && v != dhcprp_pkg::ETYPE_HI) ok_d = 1'b0;
		if (p == PW'(13) && v != dhcprp_pkg::ETYPE_LO) ok_d = 1'b0;
		if (p == PW'(23) && v != dhcprp_pkg::IP_PROTO_UDP) ok_d = 1'b0;
		if (p == PW'(14)) ihl_d = {v[3:0], 2'b00};

		udp_base = PW'(14) + PW'(ihl_d);
		r = p - udp_base;
		q = r - PW'(8);
		// Bytes 28 to 33 of the BOOTP part carry chaddr, most significant byte first.
		mac_idx = q[2:0] - 3'd4;
		mac_sh = chaddr_q << {mac_idx, 3'b000};

		if (p >= PW'(14) && p >= udp_base) begin
			if (r == PW'(2) && v != 8'd0) ok_d = 1'b0;
			if (r == PW'(3) && v != dhcprp_pkg::CLIENT_PORT) ok_d = 1'b0;
			if (r == PW'(4)) udp_len_d = {v, 8'd0};
			if (r == PW'(5)) udp_len_d = {udp_len_q[15:8], v};
			if (r >= PW'(8)) begin
				if (q == PW'(0) && v != dhcprp_pkg::BOOTREPLY) ok_d = 1'b0;
				if (q >= PW'(4) && q <= PW'(7)
						&& v != xid_q[8*(3-int'(q[1:0])) +: 8]) ok_d = 1'b0;
				if (q >= PW'(16) && q <= PW'(19)) yiaddr_d = {yiaddr_q[23:0], v};
				if (q >= PW'(28) && q <= PW'(33) && v != mac_sh[47:40]) ok_d = 1'b0;
				if (q >= PW'(236) && q <= PW'(239)
						&& v != dhcprp_pkg::MAGIC_COOKIE[8*(3-int'(q[1:0])) +: 8])
					ok_d = 1'b0;
				if (q >= PW'(240) && r < PW'(udp_len_d)) begin
					case (phase_q)
						PH_CODE: begin
							if (v == dhcprp_pkg::OPT_END) begin
								phase_d = PH_DONE;
							end else if (v != dhcprp_pkg::OPT_PAD) begin
								code_d = v;
								phase_d = PH_LEN;
							end
						end
						PH_LEN: begin
							remain_d = v;
							shift_d = '0;
							taken_d = '0;
							pcnt_d = '0;
							if (v == 8'd0) begin
								commit = 1'b1;
								phase_d = PH_CODE;
							end else begin
								phase_d = PH_VALUE;
							end
						end
						PH_VALUE: begin
							if (code_q == dhcprp_pkg::OPT_DNS) begin
								shift_d = {shift_q[23:0], v};
								// Each completed 4-byte group, up to MAX_DNS of them, becomes one server entry.
								if (taken_q[1:0] == 2'd3 && slot < 6'(MAX_DNS)) begin
									for (int i = 0; i < MAX_DNS; i++) begin
										if (slot == 6'(i)) pend_d[i] = shift_d;
									end
									pcnt_d = CW'(slot + 6'd1);
								end
							end else if (taken_q < 8'd4) begin
								shift_d = {shift_q[23:0], v};
							end
							taken_d = taken_q + 8'd1;
							remain_d = remain_q - 8'd1;
							if (remain_q == 8'd1) begin
								commit = 1'b1;
								phase_d = PH_CODE;
							end
						end
						default: ;
					endcase
				end
			end
		end

		if (commit) begin
			case (code_q)
				dhcprp_pkg::OPT_TYPE: begin
					if (taken_d == 8'd1) type_d = shift_d[7:0];
					else if (taken_d == 8'd2) type_d = shift_d[15:8];
					else if (taken_d == 8'd3) type_d = shift_d[23:16];
					else if (taken_d >= 8'd4) type_d = shift_d[31:24];
				end
				dhcprp_pkg::OPT_MASK: if (taken_d >= 8'd4) mask_d = shift_d;
				dhcprp_pkg::OPT_ROUTER: if (taken_d >= 8'd4) router_d = shift_d;
				dhcprp_pkg::OPT_SERVER: if (taken_d >= 8'd4) server_d = shift_d;
				dhcprp_pkg::OPT_LEASE: if (taken_d >= 8'd4) lease_d = shift_d;
				dhcprp_pkg::OPT_T1: if (taken_d >= 8'd4) t1_d = shift_d;
				dhcprp_pkg::OPT_T2: if (taken_d >= 8'd4) t2_d = shift_d;
				dhcprp_pkg::OPT_DNS: begin
					for (int i = 0; i < MAX_DNS; i++) store_d[i] = pend_d[i];
					cnt_d = pcnt_d;
				end
				default: ;
			endcase
		end

		frame_len = {1'b0, p} + (PW+1)'(1);
		opt0 = (PW+1)'(udp_base) + (PW+1)'(248);
		if (type_d <= 8'd7) want = types_q >> type_d[2:0];
		accept_frame = ok_d && frame_len >= opt0 && udp_len_d >= dhcprp_pkg::MIN_UDP_LEN
			&& type_d != 8'd0 && type_d <= 8'd7 && want[0]
			&& !(type_d == dhcprp_pkg::MSG_OFFER && (yiaddr_d == '0 || server_d == '0));
	end

	assign load = go && last_s1 && accept_frame;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			ihl_q <= '0;
			udp_len_q <= '0;
			ok_q <= 1'b1;
			phase_q <= PH_CODE;
			code_q <= '0;
			remain_q <= '0;
			taken_q <= '0;
			shift_q <= '0;
			type_q <= '0;
			yiaddr_q <= '0;
			mask_q <= '0;
			router_q <= '0;
			server_q <= '0;
			lease_q <= '0;
			t1_q <= '0;
			t2_q <= '0;
			smac_q <= '0;
			cnt_q <= '0;
			pcnt_q <= '0;
			for (int i = 0; i < MAX_DNS; i++) begin
				store_q[i] <= '0;
				pend_q[i] <= '0;
			end
		end else if (go) begin
			if (last_s1) begin
				pos_q <= '0;
				ihl_q <= '0;
				udp_len_q <= '0;
				ok_q <= 1'b1;
				phase_q <= PH_CODE;
				code_q <= '0;
				remain_q <= '0;
				taken_q <= '0;
				shift_q <= '0;
				type_q <= '0;
				yiaddr_q <= '0;
				mask_q <= '0;
				router_q <= '0;
				server_q <= '0;
				lease_q <= '0;
				t1_q <= '0;
				t2_q <= '0;
				smac_q <= '0;
				cnt_q <= '0;
				pcnt_q <= '0;
				for (int i = 0; i < MAX_DNS; i++) begin
					store_q[i] <= '0;
					pend_q[i] <= '0;
				end
			end else begin
				if (pos_q != dhcprp_pkg::POS_MAX) pos_q <= pos_q + PW'(1);
				ihl_q <= ihl_d;
				udp_len_q <= udp_len_d;
				ok_q <= ok_d;
				phase_q <= phase_d;
				code_q <= code_d;
				remain_q <= remain_d;
				taken_q <= taken_d;
				shift_q <= shift_d;
				type_q <= type_d;
				yiaddr_q <= yiaddr_d;
				mask_q <= mask_d;
				router_q <= router_d;
				server_q <= server_d;
				lease_q <= lease_d;
				t1_q <= t1_d;
				t2_q <= t2_d;
				smac_q <= smac_d;
				cnt_q <= cnt_d;
				pcnt_q <= pcnt_d;
				for (int i = 0; i < MAX_DNS; i++) begin
					store_q[i] <= store_d[i];
					pend_q[i] <= pend_d[i];
				end
			end
		end
	end

	assign lease_res = '{message_type: type_d, offered_ip: yiaddr_d, subnet_mask: mask_d,
		router_addr: router_d, server_id: server_d, lease_secs: lease_d,
		renew_secs: t1_d, rebind_secs: t2_d, server_hw_addr: smac_d};

	dhcprp_run_buf #(.MAX_DNS(MAX_DNS)) u_run_buf (
		.clk(clk),
		.arst_n(arst_n),
		.load(load),
		.lease_in(lease_res),
		.dns_in(store_d),
		.dns_cnt_in(cnt_d),
		.busy(busy),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.lease_out(lease_out),
		.dns_valid(dns_valid),
		.dns_addr(dns_addr),
		.last_of_run(last_of_run)
	);

	assign message_type = lease_out.message_type;
	assign offered_ip = lease_out.offered_ip;
	assign subnet_mask = lease_out.subnet_mask;
	assign router_addr = lease_out.router_addr;
	assign server_id = lease_out.server_id;
	assign lease_secs = lease_out.lease_secs;
	assign renew_secs = lease_out.renew_secs;
	assign rebind_secs = lease_out.rebind_secs;
	assign server_hw_addr = lease_out.server_hw_addr;

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the DHCP reply parser, with a built-in frame predictor.
`timescale 1ns / 1ps

module tb_top;

	localparam int N_DNS = dhcprp_pkg::DEFAULT_MAX_DNS;
	localparam int CYCLE_LIMIT = 3000000;

	typedef enum logic [1:0] {WALK_CODE, WALK_LEN, WALK_VALUE, WALK_DONE} walk_t;

	typedef struct {
		logic [7:0] b;
		logic       eof;
	} frame_byte_t;

	typedef struct {
		dhcprp_pkg::lease_t lease;
		logic        dns_ok;
		logic [31:0] dns;
		logic        last;
	} lease_result_t;

	typedef enum int {
		FR_GOOD, FR_BAD_ETYPE, FR_BAD_PROTO, FR_BAD_PORT, FR_BAD_OP, FR_BAD_XID,
		FR_BAD_CHADDR, FR_BAD_COOKIE, FR_TRUNC, FR_SHORT_UDP, FR_NOISE, FR_HUGE
	} frame_kind_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] frame_byte = 8'd0;
	logic end_of_frame = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [7:0] message_type;
	logic [31:0] offered_ip, subnet_mask, router_addr, server_id;
	logic [31:0] lease_secs, renew_secs, rebind_secs;
	logic [47:0] server_hw_addr;
	logic dns_valid;
	logic [31:0] dns_addr;
	logic last_of_run;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [dhcprp_pkg::ADDR_W-1:0] paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic pready;

	dhcp_reply_parser u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.frame_byte(frame_byte), .end_of_frame(end_of_frame),
		.out_valid(out_valid), .out_ready(out_ready),
		.message_type(message_type), .offered_ip(offered_ip),
		.subnet_mask(subnet_mask), .router_addr(router_addr),
		.server_id(server_id), .lease_secs(lease_secs),
		.renew_secs(renew_secs), .rebind_secs(rebind_secs),
		.server_hw_addr(server_hw_addr), .dns_valid(dns_valid),
		.dns_addr(dns_addr), .last_of_run(last_of_run),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Register copies as seen by the predictor.
	logic [31:0] cfg_xid = '0;
	logic [47:0] cfg_mac = '0;
	logic [7:0]  cfg_types = '0;

	// Predictor state for the frame in flight.
	logic [16:0] rx_pos;
	int unsigned hdr_len;
	logic [15:0] udp_len;
	bit          hdr_ok;
	walk_t       walk;
	logic [7:0]  opt_code;
	logic [7:0]  opt_left;
	logic [31:0] opt_value;
	int unsigned opt_bytes;
	logic [31:0] f_type, f_yiaddr, f_mask, f_router, f_server, f_lease, f_t1, f_t2;
	logic [47:0] src_mac;
	logic [31:0] dns_kept [N_DNS];
	logic [31:0] dns_new [N_DNS];
	int unsigned dns_kept_n, dns_new_n;

	frame_byte_t   pending_bytes [$];
	lease_result_t expected_leases [$];
	int errors = 0;
	int results_seen = 0;
	int tx_idle_pct = 15;
	int rx_idle_pct = 66;
	bit hold_req = 0;
	int hold_cycles = 0;
	bit hold_done = 0;
	int cycles = 0;

	function automatic void clear_frame_state();
		rx_pos = '0;
		hdr_len = 0;
		udp_len = '0;
		hdr_ok = 1;
		walk = WALK_CODE;
		opt_code = '0;
		opt_left = '0;
		opt_value = '0;
		opt_bytes = 0;
		{f_type, f_yiaddr, f_mask, f_router, f_server, f_lease, f_t1, f_t2} = '0;
		src_mac = '0;
		for (int i = 0; i < N_DNS; i++) begin
			dns_kept[i] = '0;
			dns_new[i] = '0;
		end
		dns_kept_n = 0;
		dns_new_n = 0;
	endfunction

	function automatic void keep_option();
		int unsigned n;
		case (opt_code)
			dhcprp_pkg::OPT_TYPE: if (opt_bytes >= 1) begin
				n = opt_bytes < 4 ? opt_bytes : 4;
				f_type = (opt_value >> (8 * (n - 1))) & 32'hFF;
			end
			dhcprp_pkg::OPT_MASK: if (opt_bytes >= 4) f_mask = opt_value;
			dhcprp_pkg::OPT_ROUTER: if (opt_bytes >= 4) f_router = opt_value;
			dhcprp_pkg::OPT_SERVER: if (opt_bytes >= 4) f_server = opt_value;
			dhcprp_pkg::OPT_LEASE: if (opt_bytes >= 4) f_lease = opt_value;
			dhcprp_pkg::OPT_T1: if (opt_bytes >= 4) f_t1 = opt_value;
			dhcprp_pkg::OPT_T2: if (opt_bytes >= 4) f_t2 = opt_value;
			dhcprp_pkg::OPT_DNS: begin
				dns_kept = dns_new;
				dns_kept_n = dns_new_n;
			end
			default: ;
		endcase
	endfunction

	function automatic void walk_options(logic [7:0] v);
		int unsigned slot;
		case (walk)
			WALK_CODE: if (v == dhcprp_pkg::OPT_END) begin
				walk = WALK_DONE;
			end else if (v != dhcprp_pkg::OPT_PAD) begin
				opt_code = v;
				walk = WALK_LEN;
			end
			WALK_LEN: begin
				opt_left = v;
				opt_value = '0;
				opt_bytes = 0;
				dns_new_n = 0;
				if (v == 0) begin
					keep_option();
					walk = WALK_CODE;
				end else begin
					walk = WALK_VALUE;
				end
			end
			WALK_VALUE: begin
				if (opt_code == dhcprp_pkg::OPT_DNS) begin
					opt_value = {opt_value[23:0], v};
					slot = opt_bytes >> 2;
					if ((opt_bytes & 3) == 3 && slot < N_DNS) begin
						dns_new[slot] = opt_value;
						dns_new_n = slot + 1;
					end
				end else if (opt_bytes < 4) begin
					opt_value = {opt_value[23:0], v};
				end
				opt_bytes++;
				opt_left = opt_left - 8'd1;
				if (opt_left == 0) begin
					keep_option();
					walk = WALK_CODE;
				end
			end
			default: ;
		endcase
	endfunction

	function automatic void parse_byte(int unsigned p, logic [7:0] v);
		int unsigned u, r, q;
		if (p >= 6 && p <= 11) src_mac = {src_mac[39:0], v};
		if (p == 12 && v != dhcprp_pkg::ETYPE_HI) hdr_ok = 0;
		if (p == 13 && v != dhcprp_pkg::ETYPE_LO) hdr_ok = 0;
		if (p == 23 && v != dhcprp_pkg::IP_PROTO_UDP) hdr_ok = 0;
		if (p == 14) hdr_len = v[3:0] * 4;
		if (p < 14) return;
		u = 14 + hdr_len;
		if (p < u) return;
		r = p - u;
		if (r == 2 && v != 8'd0) hdr_ok = 0;
		if (r == 3 && v != dhcprp_pkg::CLIENT_PORT) hdr_ok = 0;
		if (r == 4) udp_len = {v, 8'd0};
		if (r == 5) udp_len[7:0] = v;
		if (r < 8) return;
		q = r - 8;
		if (q == 0 && v != dhcprp_pkg::BOOTREPLY) hdr_ok = 0;
		if (q >= 4 && q <= 7 && v != cfg_xid[8 * (7 - q) +: 8]) hdr_ok = 0;
		if (q >= 16 && q <= 19) f_yiaddr = {f_yiaddr[23:0], v};
		if (q >= 28 && q <= 33 && v != cfg_mac[8 * (33 - q) +: 8]) hdr_ok = 0;
		if (q >= 236 && q <= 239 && v != dhcprp_pkg::MAGIC_COOKIE[8 * (239 - q) +: 8])
			hdr_ok = 0;
		if (q >= 240 && r < udp_len) walk_options(v);
	endfunction

	// Takes one accepted byte and queues the lease results that a final byte releases.
	function automatic void predict_lease(logic [7:0] v, logic last);
		int unsigned p, runs;
		bit ok;
		lease_result_t res;
		p = rx_pos;
		parse_byte(p, v);
		if (rx_pos != dhcprp_pkg::POS_MAX) rx_pos = rx_pos + 1'b1;
		if (!last) return;
		ok = hdr_ok && (p + 1 >= 14 + hdr_len + 8 + 240) &&
			udp_len >= dhcprp_pkg::MIN_UDP_LEN &&
			f_type != 0 && f_type <= 7 && cfg_types[f_type[2:0]] &&
			!(f_type == dhcprp_pkg::MSG_OFFER && (f_yiaddr == 0 || f_server == 0));
		if (ok) begin
			runs = dns_kept_n == 0 ? 1 : dns_kept_n;
			for (int k = 0; k < runs; k++) begin
				res.lease = '{f_type[7:0], f_yiaddr, f_mask, f_router, f_server,
					f_lease, f_t1, f_t2, src_mac};
				res.dns_ok = dns_kept_n != 0;
				res.dns = dns_kept_n != 0 ? dns_kept[k] : 32'd0;
				res.last = k + 1 == runs;
				expected_leases.push_back(res);
			end
		end
		clear_frame_state();
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("ERROR @%0t: %s got %0h expected %0h", $time, what, got, want);
		errors++;
	endtask

	// Request driver.
	always @(posedge clk) begin
		frame_byte_t it;
		if (in_valid && in_ready) predict_lease(frame_byte, end_of_frame);
		if (!in_valid || in_ready) begin
			if (arst_n && pending_bytes.size() > 0 &&
					$urandom_range(99) >= tx_idle_pct) begin
				it = pending_bytes.pop_front();
				in_valid <= 1'b1;
				frame_byte <= it.b;
				end_of_frame <= it.eof;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Long receiver hold-off, counted on its own; it spans several frames so that
	// a final byte has to wait behind a pending run.
	always @(posedge clk) begin
		if (hold_req && !hold_done) begin
			hold_cycles <= 3000;
			hold_done <= 1;
		end else if (hold_cycles != 0) begin
			hold_cycles <= hold_cycles - 1;
		end
	end

	// Result monitor.
	always @(posedge clk) begin
		lease_result_t e;
		if (out_valid && out_ready) begin
			results_seen++;
			if (expected_leases.size() == 0) begin
				report_mismatch("unexpected result, message_type", message_type, 0);
			end else begin
				e = expected_leases.pop_front();
				if (message_type !== e.lease.message_type)
					report_mismatch("message_type", message_type, e.lease.message_type);
				if (offered_ip !== e.lease.offered_ip)
					report_mismatch("offered_ip", offered_ip, e.lease.offered_ip);
				if (subnet_mask !== e.lease.subnet_mask)
					report_mismatch("subnet_mask", subnet_mask, e.lease.subnet_mask);
				if (router_addr !== e.lease.router_addr)
					report_mismatch("router_addr", router_addr, e.lease.router_addr);
				if (server_id !== e.lease.server_id)
					report_mismatch("server_id", server_id, e.lease.server_id);
				if (lease_secs !== e.lease.lease_secs)
					report_mismatch("lease_secs", lease_secs, e.lease.lease_secs);
				if (renew_secs !== e.lease.renew_secs)
					report_mismatch("renew_secs", renew_secs, e.lease.renew_secs);
				if (rebind_secs !== e.lease.rebind_secs)
					report_mismatch("rebind_secs", rebind_secs, e.lease.rebind_secs);
				if (server_hw_addr !== e.lease.server_hw_addr)
					report_mismatch("server_hw_addr", server_hw_addr,
						e.lease.server_hw_addr);
				if (dns_valid !== e.dns_ok)
					report_mismatch("dns_valid", dns_valid, e.dns_ok);
				if (dns_addr !== e.dns)
					report_mismatch("dns_addr", dns_addr, e.dns);
				if (last_of_run !== e.last)
					report_mismatch("last_of_run", last_of_run, e.last);
			end
		end
		out_ready <= arst_n && hold_cycles == 0 && $urandom_range(99) >= rx_idle_pct;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic apb_write(logic [1:0] idx, logic [63:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= dhcprp_pkg::ADDR_W'(idx * 8);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			dhcprp_pkg::REG_XID: cfg_xid = value[31:0];
			dhcprp_pkg::REG_CHADDR: cfg_mac = value[47:0];
			dhcprp_pkg::REG_TYPES: cfg_types = value[7:0];
			default: ;
		endcase
	endtask

	task automatic configure(logic [31:0] xid, logic [47:0] mac, logic [7:0] types);
		apb_write(dhcprp_pkg::REG_XID, {32'd0, xid});
		apb_write(dhcprp_pkg::REG_CHADDR, {16'd0, mac});
		apb_write(dhcprp_pkg::REG_TYPES, {56'd0, types});
	endtask

	// Sender pauses until every expected result is out and the block has settled.
	task automatic wait_drained();
		while (pending_bytes.size() != 0 || in_valid || expected_leases.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic wait_backlog();
		while (pending_bytes.size() > 400) @(posedge clk);
	endtask

	function automatic void put_byte(ref logic [7:0] fr[$], input int idx, logic [7:0] v);
		while (fr.size() <= idx) fr.push_back($urandom_range(255));
		fr[idx] = v;
	endfunction

	function automatic void push_be(ref logic [7:0] q[$], input logic [31:0] v);
		for (int i = 3; i >= 0; i--) q.push_back(v[8 * i +: 8]);
	endfunction

	// Builds one frame of the given kind and queues its bytes.
	function automatic void queue_frame(frame_kind_t kind, int ihl, logic [7:0] mtype);
		logic [7:0] fr[$];
		logic [7:0] opts[$];
		int u, b, n, len, code, ulen, total;
		logic [31:0] yi;
		if (kind == FR_NOISE) begin
			n = $urandom_range(80, 1);
			for (int i = 0; i < n; i++)
				pending_bytes.push_back('{$urandom_range(255), i == n - 1});
			return;
		end
		// Options: message type first, then a random mix.
		len = ($urandom_range(7) == 0) ? $urandom_range(3) : 1;
		opts.push_back(dhcprp_pkg::OPT_TYPE);
		opts.push_back(len);
		for (int i = 0; i < len; i++) opts.push_back(mtype);
		if (mtype == dhcprp_pkg::MSG_OFFER && $urandom_range(7) != 0) begin
			opts.push_back(dhcprp_pkg::OPT_SERVER);
			opts.push_back(8'd4);
			push_be(opts, $urandom | 32'h1);
		end
		n = $urandom_range(7);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(9))
				0: code = dhcprp_pkg::OPT_MASK;
				1: code = dhcprp_pkg::OPT_ROUTER;
				2: code = dhcprp_pkg::OPT_SERVER;
				3: code = dhcprp_pkg::OPT_LEASE;
				4: code = dhcprp_pkg::OPT_T1;
				5: code = dhcprp_pkg::OPT_T2;
				6, 7: code = dhcprp_pkg::OPT_DNS;
				8: code = dhcprp_pkg::OPT_PAD;
				default: code = $urandom_range(254, 1);
			endcase
			opts.push_back(code);
			if (code == dhcprp_pkg::OPT_PAD) continue;
			if (code == dhcprp_pkg::OPT_DNS)
				len = 4 * $urandom_range(4) + (($urandom_range(4) == 0) ? $urandom_range(3) : 0);
			else if (code == dhcprp_pkg::OPT_TYPE || code > dhcprp_pkg::OPT_T2
					|| $urandom_range(5) == 0)
				len = $urandom_range(6);
			else
				len = 4;
			opts.push_back(len);
			for (int j = 0; j < len; j++) opts.push_back($urandom_range(255));
		end
		if ($urandom_range(5) != 0) opts.push_back(dhcprp_pkg::OPT_END);
		n = $urandom_range(6);
		for (int i = 0; i < n; i++) opts.push_back($urandom_range(255));

		for (int i = 0; i < 12; i++) fr.push_back($urandom_range(255));
		fr.push_back(kind == FR_BAD_ETYPE ? 8'h86 : dhcprp_pkg::ETYPE_HI);
		fr.push_back(dhcprp_pkg::ETYPE_LO);
		for (int i = 0; i < 20; i++) fr.push_back($urandom_range(255));
		fr[23] = kind == FR_BAD_PROTO ? 8'd6 : dhcprp_pkg::IP_PROTO_UDP;
		fr[14] = {4'h4, 4'(ihl)};
		u = 14 + 4 * ihl;
		b = u + 8;
		ulen = 8 + 240 + opts.size();
		if (kind == FR_SHORT_UDP) ulen = $urandom_range(247, 0);
		else if ($urandom_range(5) == 0) ulen = 248 + $urandom_range(opts.size());
		put_byte(fr, u, $urandom_range(255));
		put_byte(fr, u + 1, $urandom_range(255));
		put_byte(fr, u + 2, 8'd0);
		put_byte(fr, u + 3, kind == FR_BAD_PORT ? 8'd67 : dhcprp_pkg::CLIENT_PORT);
		put_byte(fr, u + 4, ulen[15:8]);
		put_byte(fr, u + 5, ulen[7:0]);
		put_byte(fr, u + 6, $urandom_range(255));
		put_byte(fr, u + 7, $urandom_range(255));
		put_byte(fr, b, kind == FR_BAD_OP ? 8'd1 : dhcprp_pkg::BOOTREPLY);
		for (int i = 0; i < 4; i++)
			put_byte(fr, b + 4 + i, cfg_xid[8 * (3 - i) +: 8] ^
				((kind == FR_BAD_XID && i == 3) ? 8'h10 : 8'h00));
		yi = ($urandom_range(7) == 0) ? 32'd0 : $urandom;
		for (int i = 0; i < 4; i++) put_byte(fr, b + 16 + i, yi[8 * (3 - i) +: 8]);
		for (int i = 0; i < 6; i++)
			put_byte(fr, b + 28 + i, cfg_mac[8 * (5 - i) +: 8] ^
				((kind == FR_BAD_CHADDR && i == 0) ? 8'h80 : 8'h00));
		for (int i = 0; i < 4; i++)
			put_byte(fr, b + 236 + i, dhcprp_pkg::MAGIC_COOKIE[8 * (3 - i) +: 8] ^
				((kind == FR_BAD_COOKIE && i == 2) ? 8'h01 : 8'h00));
		// Fill unset BOOTP bytes up to the option area.
		if (fr.size() < b + 240) put_byte(fr, b + 239, fr[b + 239 < fr.size() ? b + 239 : 0]);
		put_byte(fr, b + 239, dhcprp_pkg::MAGIC_COOKIE[7:0]);
		foreach (opts[i]) fr.push_back(opts[i]);
		if (kind == FR_HUGE)
			for (int i = 0; i < 132000; i++) fr.push_back($urandom_range(255));
		total = fr.size();
		if (kind == FR_TRUNC) total = $urandom_range(b + 239, 1);
		else if ($urandom_range(7) == 0) total = b + 240 + $urandom_range(opts.size());
		for (int i = 0; i < total; i++) pending_bytes.push_back('{fr[i], i == total - 1});
	endfunction

	function automatic logic [7:0] pick_type();
		case ($urandom_range(9))
			0: return 8'd0;
			1: return $urandom_range(255, 8);
			default: return $urandom_range(7, 1);
		endcase
	endfunction

	function automatic int pick_ihl();
		return ($urandom_range(5) == 0) ? $urandom_range(15) : 5;
	endfunction

	// Mostly well-formed replies, the rest broken.
	function automatic frame_kind_t pick_kind();
		int k;
		k = $urandom_range(19);
		return k < 11 ? FR_GOOD : frame_kind_t'(k - 10);
	endfunction

	task automatic random_frames(int target, int cap);
		int start;
		start = results_seen + expected_leases.size();
		for (int f = 0; f < cap && results_seen - start < target; f++) begin
			queue_frame(pick_kind(), pick_ihl(), pick_type());
			wait_backlog();
		end
		wait_drained();
	endtask

	initial begin
		clear_frame_state();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		configure($urandom, {$urandom, $urandom} & 48'hFFFF_FFFF_FFFF, 8'hFF);

		// Directed frames: every check broken once, extreme header lengths, all types.
		for (int k = FR_GOOD; k <= FR_NOISE; k++)
			queue_frame(frame_kind_t'(k), 5, 8'd5);
		queue_frame(FR_GOOD, 0, 8'd1);
		queue_frame(FR_GOOD, 4, 8'd3);
		queue_frame(FR_GOOD, 15, 8'd7);
		for (int t = 0; t <= 8; t++) queue_frame(FR_GOOD, 5, t);
		queue_frame(FR_GOOD, 5, 8'd255);
		wait_drained();

		random_frames(15, 80);
		tx_idle_pct = 66;
		rx_idle_pct = 15;
		configure(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, $urandom_range(255) | 8'h04);
		random_frames(15, 60);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		configure(32'd0, 48'd0, 8'h00);
		random_frames(1, 6);
		configure($urandom, {$urandom, $urandom} & 48'hFFFF_FFFF_FFFF, 8'h80);
		random_frames(1, 10);
		configure($urandom, {$urandom, $urandom} & 48'hFFFF_FFFF_FFFF, 8'hFE);
		hold_req = 1;
		random_frames(15, 80);
		queue_frame(FR_HUGE, 5, 8'd5);
		queue_frame(FR_GOOD, 5, 8'd5);
		wait_drained();
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule
